### design/bcdkt_pkg.sv
// ----------------------------------------------------------------------------
// bcdkt_pkg: shared types and helpers for the BCD clock and kitchen timer
// Mode and event codes, the result word layout and the nibble-wise BCD steps.
// ----------------------------------------------------------------------------
package bcdkt_pkg;

  typedef enum logic [2:0] {
    MODE_TIME  = 3'd0,
    MODE_HOUR  = 3'd1,
    MODE_MIN   = 3'd2,
    MODE_PSEL  = 3'd3,
    MODE_RUN   = 3'd4,
    MODE_PAUSE = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_LONG_HOLD   = 2'd0,
    CFG_HOLD_SET_TO = 2'd1,
    CFG_PRESS_SET_TO = 2'd2,
    CFG_PRESET_TO   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgW = 6;

  localparam logic [7:0] BCD_59    = 8'h59;
  localparam logic [7:0] BCD_60    = 8'h60;
  localparam logic [7:0] BCD_24    = 8'h24;
  localparam logic [7:0] BCD_99    = 8'h99;
  localparam logic [7:0] BLANK     = 8'hFF;
  localparam logic [7:0] HOUR_RST  = 8'h12;
  localparam logic [7:0] PRESET_01 = 8'h01;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] disp_left;
    logic [7:0] disp_right;
    logic       blink;
  } res_t;

  // Increment, hold at 99. A low nibble of F carries into bit 4 by OR.
  function automatic logic [7:0] bcd_up(input logic [7:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [8:0] r;
    lo = {1'b0, v[3:0]};
    hi = {1'b0, v[7:4]};
    if (v[3:0] == 4'd9) begin
      lo = 5'd0;
      hi = hi + 5'd1;
    end else begin
      lo = lo + 5'd1;
    end
    r = {4'd0, lo} | {hi[4:0], 4'd0};
    return (v == BCD_99) ? v : r[7:0];
  endfunction

  // Decrement, hold at 00.
  function automatic logic [7:0] bcd_down(input logic [7:0] v);
    logic [3:0] lo;
    logic [3:0] hi;
    lo = v[3:0];
    hi = v[7:4];
    if (lo == 4'd0) begin
      hi = hi - 4'd1;
      lo = 4'd9;
    end else begin
      lo = lo - 4'd1;
    end
    return (v == 8'h00) ? 8'h00 : {hi, lo};
  endfunction

  // Next entry of the preset list; anything off the list restarts at 01.
  function automatic logic [7:0] preset_next(input logic [7:0] v);
    logic [7:0] r;
    unique case (v)
      8'h01:   r = 8'h06;
      8'h06:   r = 8'h10;
      8'h10:   r = 8'h18;
      8'h18:   r = 8'h20;
      8'h20:   r = 8'h25;
      8'h25:   r = 8'h30;
      8'h30:   r = 8'h60;
      8'h60:   r = 8'h90;
      default: r = PRESET_01;
    endcase
    return r;
  endfunction

endpackage

### design/bcd_clock_with_kitchen_timer_unit.sv
// ----------------------------------------------------------------------------
// bcd_clock_with_kitchen_timer_unit: 24-hour BCD clock with kitchen countdown
// Event driven mode control, clock, preset list and countdown in one pass.
// ----------------------------------------------------------------------------
// Each input word is one event (second tick, left press, right press, with the
// left button level) and yields exactly one output word: the mode after the
// event, both BCD display bytes (0xFF blanks a pair) and the colon dot. The
// unit takes one event per clock cycle while s_axis_tready is high, so the
// throughput is one word per cycle; the state update is a single short pass of
// BCD logic, and a result is registered once its event is accepted. An output
// register backed by a one-word skid stage decouples the two sides: s_axis_tready
// drops only when both hold a word the sink has not yet taken. The user must write
// the four timeout/hold registers through cfg_* only while idle; the unit does not enforce it.
module bcd_clock_with_kitchen_timer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [bcdkt_pkg::CfgW-1:0] cfg_data_i,
  // event stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [0] left_held, [7:1] zero
  input  logic [1:0]                 s_axis_tuser,  // [1:0] opcode
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // [7:0] display_left,
                                                    // [15:8] display_right,
                                                    // [16] blink_dot, rest zero
  output logic [2:0]                 m_axis_tuser   // [2:0] mode
);
  import bcdkt_pkg::*;

  // configuration
  logic [CfgW-1:0] long_hold_q, hold_set_to_q, press_set_to_q, preset_to_q;

  // block state
  mode_e      mode_q, mode_d;
  logic [7:0] sec_q, sec_d, min_q, min_d, hour_q, hour_d;
  logic [7:0] preset_q, preset_d, cnt_min_q, cnt_min_d, cnt_sec_q, cnt_sec_d;
  logic [CfgW-1:0] psel_idle_q, psel_idle_d, set_idle_q, set_idle_d;
  logic [7:0] hold_q, hold_d;
  logic       blink_q, blink_d;

  // output register and skid stage
  res_t res_d, out_q, skid_q;
  logic out_vld_q, skid_vld_q;
  logic in_acc, out_take;

  assign s_axis_tready = ~skid_vld_q;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_take      = out_vld_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q    <= CfgW'(5);
      hold_set_to_q  <= CfgW'(20);
      press_set_to_q <= CfgW'(10);
      preset_to_q    <= CfgW'(30);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LONG_HOLD:    long_hold_q    <= cfg_data_i;
        CFG_HOLD_SET_TO:  hold_set_to_q  <= cfg_data_i;
        CFG_PRESS_SET_TO: press_set_to_q <= cfg_data_i;
        CFG_PRESET_TO:    preset_to_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state for one event, steps in the order the timer defines them.
  always_comb begin
    mode_d      = mode_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hour_d      = hour_q;
    preset_d    = preset_q;
    cnt_min_d   = cnt_min_q;
    cnt_sec_d   = cnt_sec_q;
    psel_idle_d = psel_idle_q;
    set_idle_d  = set_idle_q;
    hold_d      = hold_q;
    blink_d     = blink_q;

    unique case (s_axis_tuser)
      OP_TICK: begin
        // preset selection times out
        if (mode_d == MODE_PSEL) begin
          psel_idle_d = psel_idle_q - CfgW'(1);
          if (psel_idle_d == '0) mode_d = MODE_TIME;
        end
        blink_d = ~blink_q;
        // countdown, frozen while paused
        if (mode_d != MODE_PAUSE && !(cnt_min_q == 8'h00 && cnt_sec_q == 8'h00)) begin
          if (cnt_sec_q == 8'h00) begin
            cnt_sec_d = BCD_59;
            cnt_min_d = bcd_down(cnt_min_q);
          end else begin
            cnt_sec_d = bcd_down(cnt_sec_q);
          end
        end
        // wall clock
        sec_d = bcd_up(sec_q);
        if (sec_d == BCD_60) begin
          sec_d = 8'h00;
          min_d = bcd_up(min_q);
        end
        if (min_d == BCD_60) begin
          min_d  = 8'h00;
          hour_d = bcd_up(hour_q);
        end
        if (hour_d == BCD_24) hour_d = 8'h00;
        // long hold of the left button forces hour setting
        hold_d = s_axis_tdata[0] ? hold_q + 8'd1 : 8'd0;
        if (hold_d > {2'b00, long_hold_q}) begin
          set_idle_d = hold_set_to_q;
          mode_d     = MODE_HOUR;
        end
        // setting modes time out
        if (mode_d == MODE_HOUR || mode_d == MODE_MIN) begin
          if (set_idle_d != '0) set_idle_d = set_idle_d - CfgW'(1);
          else mode_d = MODE_TIME;
        end
      end
      OP_LEFT: begin
        unique case (mode_q)
          MODE_HOUR, MODE_MIN: begin
            set_idle_d = press_set_to_q;
            mode_d     = (mode_q == MODE_HOUR) ? MODE_MIN : MODE_HOUR;
            sec_d      = 8'h00;
          end
          MODE_TIME: begin
            mode_d      = MODE_PSEL;
            preset_d    = PRESET_01;
            psel_idle_d = preset_to_q;
          end
          MODE_RUN: begin
            cnt_min_d = preset_q;
            cnt_sec_d = 8'h00;
          end
          MODE_PAUSE: begin
            mode_d      = MODE_PSEL;
            psel_idle_d = preset_to_q;
          end
          MODE_PSEL: begin
            psel_idle_d = preset_to_q;
            preset_d    = preset_next(preset_q);
            if (preset_q == 8'h90) mode_d = MODE_TIME;
          end
          default: ;
        endcase
      end
      OP_RIGHT: begin
        unique case (mode_q)
          MODE_HOUR: begin
            hour_d = bcd_up(hour_q);
            if (hour_d == BCD_24) hour_d = 8'h00;
            sec_d = 8'h00;
          end
          MODE_MIN: begin
            min_d = bcd_up(min_q);
            if (min_d == BCD_60) min_d = 8'h00;
            sec_d = 8'h00;
          end
          MODE_RUN:   mode_d = MODE_PAUSE;
          MODE_PAUSE: mode_d = MODE_RUN;
          MODE_PSEL: begin
            mode_d    = MODE_RUN;
            cnt_min_d = preset_q;
            cnt_sec_d = 8'h00;
          end
          default: ;
        endcase
      end
      default: ;  // unused opcode: report only
    endcase

    // display select from the updated state
    res_d.mode       = mode_d;
    res_d.blink      = blink_d;
    res_d.disp_left  = BLANK;
    res_d.disp_right = BLANK;
    unique case (mode_d)
      MODE_TIME: begin
        res_d.disp_left  = hour_d;
        res_d.disp_right = min_d;
      end
      MODE_HOUR:  res_d.disp_left  = hour_d;
      MODE_MIN:   res_d.disp_right = min_d;
      MODE_PSEL:  res_d.disp_left  = preset_d;
      MODE_RUN, MODE_PAUSE: begin
        res_d.disp_left  = cnt_min_d;
        res_d.disp_right = cnt_sec_d;
      end
      default: ;
    endcase
  end

  // Advance the state on every accepted event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TIME;
      sec_q       <= 8'h00;
      min_q       <= 8'h00;
      hour_q      <= HOUR_RST;
      preset_q    <= PRESET_01;
      cnt_min_q   <= 8'h00;
      cnt_sec_q   <= 8'h00;
      psel_idle_q <= '0;
      set_idle_q  <= '0;
      hold_q      <= 8'd0;
      blink_q     <= 1'b0;
    end else if (in_acc) begin
      mode_q      <= mode_d;
      sec_q       <= sec_d;
      min_q       <= min_d;
      hour_q      <= hour_d;
      preset_q    <= preset_d;
      cnt_min_q   <= cnt_min_d;
      cnt_sec_q   <= cnt_sec_d;
      psel_idle_q <= psel_idle_d;
      set_idle_q  <= set_idle_d;
      hold_q      <= hold_d;
      blink_q     <= blink_d;
    end
  end

  // Output register with skid: park a result in the skid stage when the
  // output word is stalled, drain it as soon as the sink takes the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!out_vld_q || out_take) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_q  <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!out_vld_q || out_take) out_q <= res_d;
      else skid_q <= res_d;
    end else if (out_take && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.mode;
  assign m_axis_tdata  = {7'd0, out_q.blink, out_q.disp_right, out_q.disp_left};

endmodule

### design/bcdkt_checker.sv
// ----------------------------------------------------------------------------
// bcdkt_checker: port-level checks for the BCD clock and kitchen timer
// Watches the stream handshakes and the display layout per mode.
// ----------------------------------------------------------------------------
module bcdkt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import bcdkt_pkg::*;

  // a result word appears only after an event was accepted
  a_result_needs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared without an accepted event");

  // the event side stalls only while a result is pending
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("event side stalled with no pending result");

  // hour setting blanks the right pair, minute setting the left pair
  a_hour_set_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == MODE_HOUR) |-> m_axis_tdata[15:8] == BLANK)
    else $error("right pair not blank in hour setting");

  a_min_set_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == MODE_MIN) |-> m_axis_tdata[7:0] == BLANK)
    else $error("left pair not blank in minute setting");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind bcd_clock_with_kitchen_timer_unit bcdkt_checker u_bcdkt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the BCD clock with kitchen timer
// Drives event words (ticks, button presses, left level), predicts the mode,
// display bytes and colon dot of each result word, and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bcdkt_pkg::*;

  // Event code 3 is not decoded by the unit: it only reports the current view.
  localparam logic [1:0]  OP_NONE        = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 150000;
  localparam int unsigned NUM_PHASES     = 7;
  localparam int unsigned PHASE_WORDS    = 100;
  localparam int unsigned HOLDOFF_CYCLES = 200;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CfgW-1:0]  cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [0] left_held, [7:1] zero
  logic [1:0]       s_axis_tuser;   // [1:0] opcode
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [23:0]      m_axis_tdata;   // [7:0] display_left, [15:8] display_right,
                                    // [16] blink_dot, rest zero
  logic [2:0]       m_axis_tuser;   // [2:0] mode

  bcd_clock_with_kitchen_timer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Clock/timer state as the bench sees it, plus its copy of the registers
  // --------------------------------------------------------------------------
  mode_e       mode_now;
  logic [7:0]  clk_sec, clk_min, clk_hr;
  logic [7:0]  preset_min, cd_min, cd_sec;
  logic [5:0]  preset_left, set_left;
  logic [7:0]  hold_cnt;
  logic        blink_now;
  logic [5:0]  cfg_long_hold, cfg_hold_set, cfg_press_set, cfg_preset;

  res_t        display_q[$];     // expected result words, oldest first
  int unsigned mismatch_count;

  // Idle and stall rates for the current phase, in percent
  int unsigned gap_pct;
  int unsigned stall_pct;
  // Long sink hold-off: the sender bumps the request count, the sink acts on it
  int unsigned holdoff_reqs;
  int unsigned holdoff_seen;
  int unsigned holdoff_left;

  // Level of the left button in random traffic, kept for a run of ticks
  logic        held_level;
  int unsigned held_ticks_left;

  typedef struct packed {
    logic [1:0] op;
    logic       held;
    logic       typed;   // 1: want is the literal expectation for this row
    res_t       want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Nibble-wise BCD increment; saturates at 99
  function automatic logic [7:0] bcd_inc(input logic [7:0] v);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = {4'd0, v[3:0]};
    hi = {4'd0, v[7:4]};
    if (v == BCD_99) return v;
    if (lo == 8'd9) begin
      lo = 8'd0;
      hi = hi + 8'd1;
    end else begin
      lo = lo + 8'd1;
    end
    return lo | (hi << 4);
  endfunction

  // Nibble-wise BCD decrement; saturates at 00
  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    logic [3:0] lo;
    logic [3:0] hi;
    lo = v[3:0];
    hi = v[7:4];
    if (v == 8'h00) return 8'h00;
    if (lo == 4'd0) begin
      hi = hi - 4'd1;
      lo = 4'd9;
    end else begin
      lo = lo - 4'd1;
    end
    return {hi, lo};
  endfunction

  // Advance the state by one event and form the word the unit should show
  task automatic apply_event(input logic [1:0] op, input logic held, output res_t r);
    case (op)
      OP_TICK: begin
        // Preset selection times out back to the clock view
        if (mode_now == MODE_PSEL) begin
          preset_left = preset_left - 6'd1;
          if (preset_left == 6'd0) mode_now = MODE_TIME;
        end
        blink_now = ~blink_now;
        // Countdown runs unless paused, and stops at 00:00
        if (mode_now != MODE_PAUSE && {cd_min, cd_sec} != 16'h0000) begin
          if (cd_sec == 8'h00) begin
            cd_sec = BCD_59;
            cd_min = bcd_dec(cd_min);
          end else begin
            cd_sec = bcd_dec(cd_sec);
          end
        end
        clk_sec = bcd_inc(clk_sec);
        if (clk_sec == BCD_60) begin
          clk_sec = 8'h00;
          clk_min = bcd_inc(clk_min);
        end
        if (clk_min == BCD_60) begin
          clk_min = 8'h00;
          clk_hr  = bcd_inc(clk_hr);
        end
        if (clk_hr == BCD_24) clk_hr = 8'h00;
        // A long hold of the left button forces hour setting
        hold_cnt = held ? hold_cnt + 8'd1 : 8'd0;
        if (hold_cnt > {2'b00, cfg_long_hold}) begin
          set_left = cfg_hold_set;
          mode_now = MODE_HOUR;
        end
        if (mode_now == MODE_HOUR || mode_now == MODE_MIN) begin
          if (set_left != 6'd0) set_left = set_left - 6'd1;
          else mode_now = MODE_TIME;
        end
      end
      OP_LEFT: begin
        case (mode_now)
          MODE_HOUR, MODE_MIN: begin
            set_left = cfg_press_set;
            mode_now = (mode_now == MODE_HOUR) ? MODE_MIN : MODE_HOUR;
            clk_sec  = 8'h00;
          end
          MODE_TIME: begin
            mode_now    = MODE_PSEL;
            preset_min  = PRESET_01;
            preset_left = cfg_preset;
          end
          MODE_RUN: begin
            cd_min = preset_min;
            cd_sec = 8'h00;
          end
          MODE_PAUSE: begin
            mode_now    = MODE_PSEL;
            preset_left = cfg_preset;
          end
          MODE_PSEL: begin
            preset_left = cfg_preset;
            // Walk the preset list; after 90 drop back to the clock view
            case (preset_min)
              8'h01:   preset_min = 8'h06;
              8'h06:   preset_min = 8'h10;
              8'h10:   preset_min = 8'h18;
              8'h18:   preset_min = 8'h20;
              8'h20:   preset_min = 8'h25;
              8'h25:   preset_min = 8'h30;
              8'h30:   preset_min = 8'h60;
              8'h60:   preset_min = 8'h90;
              8'h90: begin
                preset_min = PRESET_01;
                mode_now   = MODE_TIME;
              end
              default: preset_min = PRESET_01;
            endcase
          end
          default: ;
        endcase
      end
      OP_RIGHT: begin
        case (mode_now)
          MODE_HOUR: begin
            clk_hr = bcd_inc(clk_hr);
            if (clk_hr == BCD_24) clk_hr = 8'h00;
            clk_sec = 8'h00;
          end
          MODE_MIN: begin
            clk_min = bcd_inc(clk_min);
            if (clk_min == BCD_60) clk_min = 8'h00;
            clk_sec = 8'h00;
          end
          MODE_RUN:   mode_now = MODE_PAUSE;
          MODE_PAUSE: mode_now = MODE_RUN;
          MODE_PSEL: begin
            mode_now = MODE_RUN;
            cd_min   = preset_min;
            cd_sec   = 8'h00;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    r.mode       = mode_now;
    r.blink      = blink_now;
    r.disp_left  = BLANK;
    r.disp_right = BLANK;
    case (mode_now)
      MODE_TIME: begin
        r.disp_left  = clk_hr;
        r.disp_right = clk_min;
      end
      MODE_HOUR: r.disp_left  = clk_hr;
      MODE_MIN:  r.disp_right = clk_min;
      MODE_PSEL: r.disp_left  = preset_min;
      MODE_RUN, MODE_PAUSE: begin
        r.disp_left  = cd_min;
        r.disp_right = cd_sec;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Offer one event word and hold it until the unit takes it. tvalid stays
  // high afterwards; an idle cycle or the next word decides its next value.
  task automatic send_event(input logic [1:0] op, input logic held, input logic typed,
                            input res_t typed_res);
    res_t predicted;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, held};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_event(op, held, predicted);
    display_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic idle_cycle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Drop tvalid, let every expected word come out, then a short settle
  task automatic wait_all_results();
    idle_cycle();
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Hold cfg_we_i high across back-to-back writes; the caller lowers it
  task automatic write_setting(input cfg_idx_e idx, input logic [5:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_LONG_HOLD:    cfg_long_hold = val;
      CFG_HOLD_SET_TO:  cfg_hold_set  = val;
      CFG_PRESS_SET_TO: cfg_press_set = val;
      default:          cfg_preset    = val;
    endcase
  endtask

  task automatic add_row(input logic [1:0] op, input logic held, input logic typed,
                         input mode_e m, input logic [7:0] dl, input logic [7:0] dr,
                         input logic b);
    stim_row_t row;
    row.op              = op;
    row.held            = held;
    row.typed           = typed;
    row.want.mode       = m;
    row.want.disp_left  = dl;
    row.want.disp_right = dr;
    row.want.blink      = b;
    directed_rows.push_back(row);
  endtask

  // Random event, shaped by the predicted mode: while a clock digit is being
  // set, favor right presses so the digits roll over; elsewhere mostly ticks.
  // The left level comes in runs of ticks, some long enough to force hour set.
  task automatic pick_event(output logic [1:0] op, output logic held);
    int unsigned roll;
    int unsigned tick_lim;
    int unsigned left_lim;
    roll = $urandom_range(0, 99);
    if (mode_now == MODE_HOUR || mode_now == MODE_MIN) begin
      tick_lim = 30;
      left_lim = 45;
    end else begin
      tick_lim = 55;
      left_lim = 75;
    end
    if (roll < tick_lim)      op = OP_TICK;
    else if (roll < left_lim) op = OP_LEFT;
    else if (roll < 95)       op = OP_RIGHT;
    else                      op = OP_NONE;
    if (op == OP_TICK) begin
      if (held_ticks_left == 0) begin
        held_level      = ($urandom_range(0, 3) == 0);
        held_ticks_left = held_level ? $urandom_range(1, cfg_long_hold + 6)
                                     : $urandom_range(1, 20);
      end
      held_ticks_left--;
    end
    held = held_level;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    holdoff_seen  = 0;
    holdoff_left  = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_seen != holdoff_reqs) begin
        holdoff_seen = holdoff_reqs;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every accepted word against the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (display_q.size() == 0) begin
        $display("%0t: unexpected result word, mode %0d, tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = display_q.pop_front();
        check_field("mode", {5'd0, want.mode}, {5'd0, m_axis_tuser});
        check_field("display_left", want.disp_left, m_axis_tdata[7:0]);
        check_field("display_right", want.disp_right, m_axis_tdata[15:8]);
        check_field("blink_dot", {7'd0, want.blink}, {7'd0, m_axis_tdata[16]});
      end
    end
  end

  // Watchdog: give up well past the slowest legal run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout with %0d results outstanding", $time, display_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    logic [1:0]  op;
    logic        held;
    logic [5:0]  lh, hs, ps, pt;
    res_t        no_res;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_LONG_HOLD;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'd0;
    s_axis_tuser    = OP_TICK;
    gap_pct         = 0;
    stall_pct       = 0;
    holdoff_reqs    = 0;
    mismatch_count  = 0;
    held_level      = 1'b0;
    held_ticks_left = 0;
    no_res          = '0;

    // Reset view of the unit
    mode_now      = MODE_TIME;
    clk_sec       = 8'h00;
    clk_min       = 8'h00;
    clk_hr        = HOUR_RST;
    preset_min    = PRESET_01;
    cd_min        = 8'h00;
    cd_sec        = 8'h00;
    preset_left   = 6'd0;
    set_left      = 6'd0;
    hold_cnt      = 8'd0;
    blink_now     = 1'b0;
    cfg_long_hold = 6'd5;
    cfg_hold_set  = 6'd20;
    cfg_press_set = 6'd10;
    cfg_preset    = 6'd30;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A short hold so the directed part can force hour setting in two ticks
    write_setting(CFG_LONG_HOLD, 6'd1);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;

    // Directed: unused code, ignored right press, whole preset list and the
    // wrap back to the clock, run/pause/restart, then a forced hour set.
    add_row(OP_NONE,  1'b0, 1'b1, MODE_TIME,  8'h12, 8'h00, 1'b0);
    add_row(OP_RIGHT, 1'b0, 1'b1, MODE_TIME,  8'h12, 8'h00, 1'b0);
    add_row(OP_TICK,  1'b0, 1'b1, MODE_TIME,  8'h12, 8'h00, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h01, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h06, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h10, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h18, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h20, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h25, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h30, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h60, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h90, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_TIME,  8'h12, 8'h00, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h01, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h06, BLANK, 1'b1);
    add_row(OP_RIGHT, 1'b0, 1'b1, MODE_RUN,   8'h06, 8'h00, 1'b1);
    add_row(OP_TICK,  1'b0, 1'b0, MODE_TIME,  8'h00, 8'h00, 1'b0);
    add_row(OP_RIGHT, 1'b0, 1'b1, MODE_PAUSE, 8'h05, 8'h59, 1'b0);
    add_row(OP_TICK,  1'b0, 1'b0, MODE_TIME,  8'h00, 8'h00, 1'b0);
    add_row(OP_LEFT,  1'b0, 1'b1, MODE_PSEL,  8'h06, BLANK, 1'b1);
    add_row(OP_RIGHT, 1'b0, 1'b1, MODE_RUN,   8'h06, 8'h00, 1'b1);
    add_row(OP_TICK,  1'b1, 1'b0, MODE_TIME,  8'h00, 8'h00, 1'b0);
    add_row(OP_LEFT,  1'b1, 1'b1, MODE_RUN,   8'h06, 8'h00, 1'b0);
    add_row(OP_TICK,  1'b1, 1'b1, MODE_HOUR,  8'h12, BLANK, 1'b1);
    add_row(OP_RIGHT, 1'b1, 1'b1, MODE_HOUR,  8'h13, BLANK, 1'b1);
    add_row(OP_LEFT,  1'b1, 1'b1, MODE_MIN,   BLANK, 8'h00, 1'b1);
    add_row(OP_NONE,  1'b1, 1'b1, MODE_MIN,   BLANK, 8'h00, 1'b1);

    foreach (directed_rows[i])
      send_event(directed_rows[i].op, directed_rows[i].held, directed_rows[i].typed,
                 directed_rows[i].want);
    wait_all_results();

    // Random phases: each writes all four registers while idle, then runs
    // with its own mix of sender gaps and sink stalls.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          lh = 6'd5;  hs = 6'd20; ps = 6'd10; pt = 6'd30;
          gap_pct = 0;  stall_pct = 0;
        end
        1: begin
          lh = 6'd1;  hs = 6'd1;  ps = 6'd1;  pt = 6'd1;
          gap_pct = 60; stall_pct = 0;
        end
        2: begin
          lh = 6'd63; hs = 6'd63; ps = 6'd63; pt = 6'd63;
          gap_pct = 0;  stall_pct = 60;
        end
        3: begin
          lh = 6'd3;  hs = 6'd10; ps = 6'd5;  pt = 6'd8;
          gap_pct = 31; stall_pct = 31;
        end
        4: begin
          lh = 6'd2;  hs = 6'd40; ps = 6'd2;  pt = 6'd63;
          gap_pct = 0;  stall_pct = 0;
        end
        5: begin
          lh = 6'($urandom_range(1, 63));
          hs = 6'($urandom_range(1, 63));
          ps = 6'($urandom_range(1, 63));
          pt = 6'($urandom_range(1, 63));
          gap_pct = 60; stall_pct = 60;
        end
        default: begin
          lh = 6'd1;  hs = 6'd63; ps = 6'd1;  pt = 6'd63;
          gap_pct = 31; stall_pct = 31;
        end
      endcase
      write_setting(CFG_LONG_HOLD, lh);
      write_setting(CFG_HOLD_SET_TO, hs);
      write_setting(CFG_PRESS_SET_TO, ps);
      write_setting(CFG_PRESET_TO, pt);
      @(negedge clk_i);
      cfg_we_i <= 1'b0;

      for (n = 0; n < PHASE_WORDS; n++) begin
        // Stop the sink for a long stretch while words keep coming, so the
        // output stages fill and the unit has to push back on its input
        if (phase == 4 && n == 20) holdoff_reqs++;
        while ($urandom_range(0, 99) < gap_pct) idle_cycle();
        pick_event(op, held);
        send_event(op, held, 1'b0, no_res);
      end
      wait_all_results();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### bcd_clock_with_kitchen_timer_unit.f
design/bcdkt_pkg.sv
design/bcd_clock_with_kitchen_timer_unit.sv
design/bcdkt_checker.sv
tb/sv/tb_top.sv
